>>> rtl/core/lfsc_pkg.sv
// Shared types and constants for the link frame stuffing codec.
// Holds the input/result word structs, the internal command word and the line codes.
// No dependencies.
package lfsc_pkg;

	localparam logic [7:0] LINE_FLAG   = 8'h7E;
	localparam logic [7:0] LINE_ESC    = 8'h7D;
	localparam logic [7:0] ESC_OF_FLAG = 8'h5E;
	localparam logic [7:0] ESC_OF_ESC  = 8'h5D;
	localparam logic [7:0] ADDR_RESET  = 8'h03;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS     = 4'd1;

	// Command queue between the front and back parts.
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// Result byte positions of one encoded item, in emission order.
	localparam int NUM_SLOTS = 9;
	typedef enum logic [3:0] {
		SLOT_OPEN_FLAG  = 4'd0,
		SLOT_ADDR       = 4'd1,
		SLOT_CTRL       = 4'd2,
		SLOT_HDR_CHECK  = 4'd3,
		SLOT_DATA_FIRST = 4'd4,
		SLOT_DATA_ESC   = 4'd5,
		SLOT_CHK_FIRST  = 4'd6,
		SLOT_CHK_ESC    = 4'd7,
		SLOT_CLOSE_FLAG = 4'd8
	} lfsc_slot_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic [7:0] control_byte;
	} lfsc_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
		logic       escape_error;
	} lfsc_out_t;

	// One classified item. In decode mode data holds the recovered byte.
	typedef struct packed {
		logic       enc;
		logic       hdr;
		logic       last;
		logic       err;
		logic [7:0] addr;
		logic [7:0] ctl;
		logic [7:0] data;
		logic [7:0] chk;
	} lfsc_cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} lfsc_cq_stat_t;

	function automatic logic needs_stuff(input logic [7:0] b);
		needs_stuff = (b == LINE_FLAG) || (b == LINE_ESC);
	endfunction

	function automatic logic [7:0] esc_code(input logic [7:0] b);
		esc_code = (b == LINE_FLAG) ? ESC_OF_FLAG : ESC_OF_ESC;
	endfunction

endpackage

>>> rtl/core/lfsc_front.sv
// Front part: configuration registers, per-frame state and item classification.
// Depends on lfsc_pkg.
module lfsc_front
	import lfsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 accept,
	input  lfsc_in_t             in_data,
	output logic                 cmd_valid,
	output lfsc_cmd_t            cmd
);

	logic       decode_mode_q;
	logic [7:0] address_q;
	logic [7:0] check_q;
	logic       esc_pend_q;
	logic       at_start_q;

	logic [7:0] chk_new;
	logic       esc_pend_d;

	always_comb begin
		chk_new    = (at_start_q ? 8'h00 : check_q) ^ in_data.data_byte;
		esc_pend_d = esc_pend_q;
		cmd_valid  = 1'b1;
		cmd.enc    = !decode_mode_q;
		cmd.hdr    = at_start_q;
		cmd.last   = in_data.last_byte;
		cmd.err    = 1'b0;
		cmd.addr   = address_q;
		cmd.ctl    = in_data.control_byte;
		cmd.data   = in_data.data_byte;
		cmd.chk    = chk_new;
		if (decode_mode_q) begin
			if (esc_pend_q) begin
				esc_pend_d = 1'b0;
				if (in_data.data_byte == ESC_OF_ESC) begin
					cmd.data = LINE_ESC;
				end else if (in_data.data_byte == ESC_OF_FLAG) begin
					cmd.data = LINE_FLAG;
				end else begin
					cmd.data = 8'h00;
					cmd.err  = 1'b1;
				end
			end else if (in_data.data_byte == LINE_ESC) begin
				if (in_data.last_byte) begin
					// An escape that ends the frame has no partner.
					cmd.data = 8'h00;
					cmd.err  = 1'b1;
				end else begin
					esc_pend_d = 1'b1;
					cmd_valid  = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			address_q     <= ADDR_RESET;
			check_q       <= 8'h00;
			esc_pend_q    <= 1'b0;
			at_start_q    <= 1'b1;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_DECODE_MODE: decode_mode_q <= cfg_data[0];
					CFG_ADDRESS:     address_q     <= cfg_data;
					default:         ;
				endcase
			end
			if (accept) begin
				// Each mode keeps its own partial frame state.
				if (decode_mode_q) begin
					esc_pend_q <= esc_pend_d;
				end else begin
					check_q    <= chk_new;
					at_start_q <= in_data.last_byte;
				end
			end
		end
	end

endmodule

>>> rtl/core/lfsc_cmdq.sv
// Short command queue that decouples the front and back parts.
// Depends on lfsc_pkg.
module lfsc_cmdq
	import lfsc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lfsc_cmd_t     wr_cmd,
	input  logic          rd_en,
	output lfsc_cmd_t     rd_cmd,
	output logic          full,
	output logic          empty
);

	lfsc_cmd_t            mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0]  wr_ptr_q;
	logic [CQ_PTR_W-1:0]  rd_ptr_q;
	logic [CQ_CNT_W-1:0]  count_q;

	assign full   = (count_q == CQ_CNT_W'(CQ_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/lfsc_back.sv
// Back part: expands the command at the queue head into line bytes, one per cycle while
// the output register is free or popped, and holds the oldest result in that register. Depends on lfsc_pkg.
module lfsc_back
	import lfsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_avail,
	input  lfsc_cmd_t cmd,
	output logic      cmd_done,
	input  logic      pop,
	output logic      empty,
	output lfsc_out_t out_data
);

	logic [NUM_SLOTS-1:0] done_q;
	logic                 out_valid_q;
	lfsc_out_t            out_q;

	logic [NUM_SLOTS-1:0] full_mask;
	logic [NUM_SLOTS-1:0] rem;
	logic [NUM_SLOTS-1:0] sel_bit;
	lfsc_slot_t           sel;
	logic                 advance;
	logic                 final_slot;
	lfsc_out_t            res;

	always_comb begin
		if (cmd.enc) begin
			full_mask = {cmd.last, cmd.last && needs_stuff(cmd.chk), cmd.last,
				needs_stuff(cmd.data), 1'b1, {4{cmd.hdr}}};
		end else begin
			full_mask = '0;
			full_mask[SLOT_DATA_FIRST] = 1'b1;
		end
		rem = full_mask & ~done_q;

		// Lowest pending slot goes out first.
		sel     = SLOT_OPEN_FLAG;
		sel_bit = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				sel     = lfsc_slot_t'(i[3:0]);
				sel_bit = '0;
				sel_bit[i] = 1'b1;
			end
		end
		final_slot = ((rem & ~sel_bit) == '0);

		case (sel)
			SLOT_OPEN_FLAG:  res.out_byte = LINE_FLAG;
			SLOT_ADDR:       res.out_byte = cmd.addr;
			SLOT_CTRL:       res.out_byte = cmd.ctl;
			SLOT_HDR_CHECK:  res.out_byte = cmd.addr ^ cmd.ctl;
			SLOT_DATA_FIRST: res.out_byte = (cmd.enc && needs_stuff(cmd.data)) ?
				LINE_ESC : cmd.data;
			SLOT_DATA_ESC:   res.out_byte = esc_code(cmd.data);
			SLOT_CHK_FIRST:  res.out_byte = needs_stuff(cmd.chk) ? LINE_ESC : cmd.chk;
			SLOT_CHK_ESC:    res.out_byte = esc_code(cmd.chk);
			SLOT_CLOSE_FLAG: res.out_byte = LINE_FLAG;
			default:         res.out_byte = LINE_FLAG;
		endcase
		res.run_last     = final_slot;
		res.frame_end    = (sel == SLOT_CLOSE_FLAG) || (!cmd.enc && cmd.last);
		res.escape_error = !cmd.enc && cmd.err;

		advance  = cmd_avail && (!out_valid_q || pop);
		cmd_done = advance && final_slot;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				done_q      <= final_slot ? '0 : (done_q | sel_bit);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign out_data = out_q;

endmodule

>>> rtl/core/link_frame_stuffing_codec_top.sv
// Link frame stuffing codec: HDLC-style framer/deframer with byte stuffing.
// The command of an accepted word goes through the command queue, and each of its results
// is registered in the output register. One word per cycle is accepted while each word gives
// one result and the output is popped; a word that expands to up to 9 line bytes holds the
// back end while they go out, and a 4-entry command queue absorbs the input meanwhile. Reset
// (arst_n low) clears queue, output and frame state, selects encode mode and sets the address byte to 0x03.
module link_frame_stuffing_codec_top
	import lfsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  lfsc_in_t             in_data,
	output logic                 empty,
	input  logic                 pop,
	output lfsc_out_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic          accept;
	logic          cmd_valid;
	lfsc_cmd_t     cmd_in;
	lfsc_cmd_t     cmd_head;
	lfsc_cq_stat_t cq;

	assign cfg_ready = 1'b1;
	assign accept    = push && !cq.full;
	assign full      = cq.full;
	assign cq.push   = accept && cmd_valid;

	lfsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	lfsc_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cq.push),
		.wr_cmd (cmd_in),
		.rd_en  (cq.pop),
		.rd_cmd (cmd_head),
		.full   (cq.full),
		.empty  (cq.empty)
	);

	lfsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (!cq.empty),
		.cmd       (cmd_head),
		.cmd_done  (cq.pop),
		.pop       (pop),
		.empty     (empty),
		.out_data  (out_data)
	);

	// The back end retires only a command that is really there.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cq.pop |-> !cq.empty)
		else $error("command queue read while empty");

	// An escape error always stands alone as the single result of its word.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.escape_error) |-> (out_data.run_last && out_data.frame_end ||
			out_data.run_last))
		else $error("escape error result is not the last of its word");

	// A frame-end result that is not the flag byte is always the last result of its word.
	a_close_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.frame_end && !out_data.escape_error && out_data.out_byte != LINE_FLAG)
		|-> out_data.run_last)
		else $error("frame end word is not the last result of its word");

endmodule

>>> tb/tb_link_frame_stuffing_codec_top.sv
// Self-checking testbench for link_frame_stuffing_codec_top: encode and decode streams
// are checked against a line-byte predictor. Depends on lfsc_pkg and the codec RTL.
`timescale 1ns / 1ps

module tb_link_frame_stuffing_codec_top;
	import lfsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 4'd15;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_WORDS = 80;

	// Predicts the line bytes of every accepted word and checks them in order.
	class line_byte_predictor;
		bit         decode_mode;
		logic [7:0] address;
		logic [7:0] check_acc;
		bit         esc_pending;
		bit         frame_start;
		lfsc_out_t  bytes_due[$];
		int         errors;
		int         words;
		int         checked;

		function new();
			decode_mode = 1'b0;
			address     = ADDR_RESET;
			check_acc   = 8'h00;
			esc_pending = 1'b0;
			frame_start = 1'b1;
			errors      = 0;
			words       = 0;
			checked     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == CFG_DECODE_MODE)
				decode_mode = val[0];
			else if (idx == CFG_ADDRESS)
				address = val;
		endfunction

		function void add_byte(logic [7:0] b, logic fend, logic err);
			lfsc_out_t r;
			r.out_byte     = b;
			r.run_last     = 1'b0;
			r.frame_end    = fend;
			r.escape_error = err;
			bytes_due.push_back(r);
		endfunction

		function void add_stuffed(logic [7:0] b);
			if (b == LINE_FLAG) begin
				add_byte(LINE_ESC, 1'b0, 1'b0);
				add_byte(ESC_OF_FLAG, 1'b0, 1'b0);
			end else if (b == LINE_ESC) begin
				add_byte(LINE_ESC, 1'b0, 1'b0);
				add_byte(ESC_OF_ESC, 1'b0, 1'b0);
			end else begin
				add_byte(b, 1'b0, 1'b0);
			end
		endfunction

		function void take_word(lfsc_in_t w);
			int        size_at_start;
			lfsc_out_t tail;
			size_at_start = bytes_due.size();
			words++;
			if (!decode_mode) begin
				if (frame_start) begin
					add_byte(LINE_FLAG, 1'b0, 1'b0);
					add_byte(address, 1'b0, 1'b0);
					add_byte(w.control_byte, 1'b0, 1'b0);
					add_byte(address ^ w.control_byte, 1'b0, 1'b0);
					check_acc = 8'h00;
				end
				check_acc ^= w.data_byte;
				add_stuffed(w.data_byte);
				if (w.last_byte) begin
					add_stuffed(check_acc);
					add_byte(LINE_FLAG, 1'b1, 1'b0);
				end
				frame_start = w.last_byte;
			end else if (esc_pending) begin
				esc_pending = 1'b0;
				if (w.data_byte == ESC_OF_ESC)
					add_byte(LINE_ESC, w.last_byte, 1'b0);
				else if (w.data_byte == ESC_OF_FLAG)
					add_byte(LINE_FLAG, w.last_byte, 1'b0);
				else
					add_byte(8'h00, w.last_byte, 1'b1);
			end else if (w.data_byte == LINE_ESC) begin
				if (w.last_byte)
					add_byte(8'h00, 1'b1, 1'b1);
				else
					esc_pending = 1'b1;
			end else begin
				add_byte(w.data_byte, w.last_byte, 1'b0);
			end
			if (bytes_due.size() > size_at_start) begin
				tail = bytes_due.pop_back();
				tail.run_last = 1'b1;
				bytes_due.push_back(tail);
			end
		endfunction

		function void check_line_byte(lfsc_out_t got);
			lfsc_out_t exp;
			if (bytes_due.size() == 0) begin
				$error("unexpected line byte %02h with nothing outstanding", got.out_byte);
				errors++;
				return;
			end
			exp = bytes_due.pop_front();
			checked++;
			if (got.out_byte !== exp.out_byte) begin
				$error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
				errors++;
			end
			if (got.run_last !== exp.run_last) begin
				$error("run_last: expected %0b, got %0b", exp.run_last, got.run_last);
				errors++;
			end
			if (got.frame_end !== exp.frame_end) begin
				$error("frame_end: expected %0b, got %0b", exp.frame_end, got.frame_end);
				errors++;
			end
			if (got.escape_error !== exp.escape_error) begin
				$error("escape_error: expected %0b, got %0b",
					exp.escape_error, got.escape_error);
				errors++;
			end
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	lfsc_in_t             in_data   = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	lfsc_out_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = '0;

	line_byte_predictor line_model = new;

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int pop_stall = 0;
	int reg_writes = 0;

	link_frame_stuffing_codec_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap(bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 35);
	endfunction

	// Line codes show up far more often than chance would give them.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return LINE_FLAG;
		if (r < 40)
			return LINE_ESC;
		if (r < 45)
			return ESC_OF_FLAG;
		if (r < 50)
			return ESC_OF_ESC;
		return 8'($urandom_range(0, 255));
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_stall <= 0;
		end else if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else begin
			pop <= 1'b1;
			pop_stall <= pick_gap(rx_steady);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			line_model.check_line_byte(out_data);
	end

	// Leaves push high on return so that back-to-back words need no second assignment.
	task automatic send_word(input logic [7:0] d, input logic l, input logic [7:0] c);
		lfsc_in_t w;
		int       gap;
		logic     busy;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.data_byte    = d;
		w.last_byte    = l;
		w.control_byte = c;
		push    <= 1'b1;
		in_data <= w;
		do begin
			@(negedge clk);
			busy = full;
			@(posedge clk);
		end while (busy);
		line_model.take_word(w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		line_model.write_reg(idx, val);
		reg_writes++;
	endtask

	task automatic cfg_idle();
		cfg_valid <= 1'b0;
	endtask

	// Words that yield nothing may still be in flight once the last byte is out.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (line_model.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic enc_frame();
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
		for (int i = 0; i < len; i++)
			send_word(pick_byte(), i == len - 1, 8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed stuffed frames, with broken escapes and dangling escapes mixed in.
	task automatic dec_frame();
		int         len;
		logic [7:0] b;
		bit         fin;
		len = $urandom_range(1, 5);
		for (int i = 0; i < len; i++) begin
			fin = (i == len - 1);
			b = pick_byte();
			if ($urandom_range(0, 99) < 8) begin
				send_word(LINE_ESC, 1'b0, 8'($urandom_range(0, 255)));
				send_word(8'($urandom_range(0, 255)), fin, 8'($urandom_range(0, 255)));
			end else if (b == LINE_FLAG || b == LINE_ESC) begin
				send_word(LINE_ESC, 1'b0, 8'($urandom_range(0, 255)));
				send_word((b == LINE_FLAG) ? ESC_OF_FLAG : ESC_OF_ESC, fin,
					8'($urandom_range(0, 255)));
			end else begin
				send_word(b, fin, 8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 19) == 0)
			send_word(LINE_ESC, 1'b1, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int         directed_words;
		int         phase;
		int         phase_start;
		bit         mode;
		logic [7:0] addr;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encode with the reset address: a one-byte frame whose data and check bytes
		// both need stuffing, then a longer frame.
		send_word(LINE_FLAG, 1'b1, 8'hFF);
		send_word(LINE_ESC, 1'b0, 8'h00);
		send_word(8'h00, 1'b0, 8'h55);
		send_word(8'hFF, 1'b1, 8'hAA);
		wait_drained();
		write_reg(CFG_ADDRESS, 8'hFF);
		write_reg(CFG_IDX_UNMAPPED, 8'h01);
		cfg_idle();
		// Two flags cancel, so the check byte is zero.
		send_word(LINE_FLAG, 1'b0, 8'h81);
		send_word(LINE_FLAG, 1'b1, 8'h00);

		// Leave an encode frame open and decode in the middle of it.
		send_word(ESC_OF_FLAG, 1'b0, 8'h7E);
		wait_drained();
		write_reg(CFG_DECODE_MODE, 8'h01);
		cfg_idle();
		send_word(LINE_ESC, 1'b0, 8'h00);
		send_word(ESC_OF_FLAG, 1'b0, 8'h00);
		send_word(LINE_ESC, 1'b0, 8'hFF);
		send_word(ESC_OF_ESC, 1'b0, 8'hFF);
		send_word(LINE_ESC, 1'b0, 8'h00);
		send_word(8'h33, 1'b0, 8'h00);
		send_word(LINE_FLAG, 1'b0, 8'h00);
		send_word(8'h00, 1'b0, 8'h00);
		send_word(LINE_ESC, 1'b0, 8'h00);

		// Back to encode to close the open frame, then decode resumes its pending escape.
		wait_drained();
		write_reg(CFG_DECODE_MODE, 8'h00);
		write_reg(CFG_ADDRESS, 8'h00);
		cfg_idle();
		send_word(LINE_ESC, 1'b1, 8'h00);
		wait_drained();
		write_reg(CFG_DECODE_MODE, 8'h01);
		cfg_idle();
		send_word(ESC_OF_ESC, 1'b1, 8'h00);
		send_word(8'hFF, 1'b1, 8'hFF);
		send_word(LINE_ESC, 1'b1, 8'h00);
		directed_words = line_model.words;

		phase = 0;
		while (line_model.words < directed_words + RANDOM_WORDS) begin
			wait_drained();
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			mode = (phase % 3 == 1);
			case (phase % 4)
				0: begin
					addr = 8'h00;
				end
				1: begin
					addr = 8'hFF;
				end
				default: begin
					addr = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(CFG_DECODE_MODE, {7'd0, mode});
			write_reg(CFG_ADDRESS, addr);
			cfg_idle();
			phase_start = line_model.words;
			while (line_model.words - phase_start < 16) begin
				if (mode)
					dec_frame();
				else
					enc_frame();
			end
			phase++;
		end

		wait_drained();
		$display("Covered %0d words in both modes over %0d register writes and %0d phases;",
			line_model.words, reg_writes, phase + 4);
		$display("%0d line bytes were checked against the predictor.", line_model.checked);
		if (line_model.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
